// File: rtl/mvaa_pkg.sv
package mvaa_pkg;

  // Coordinate grid and derived datapath widths
  localparam int COORD_BITS = 12;
  localparam int FIELD_W    = 12;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int N_W        = 2 * COORD_BITS + 2;
  localparam int ACC_W      = 4 * COORD_BITS + 4;
  localparam int ROOT_W     = ACC_W / 2;
  localparam int DIGIT_W    = 4;
  localparam int SQ_CNT_W   = $clog2(ROOT_W + 1);

  // Result fields
  localparam int VOL_W      = 52;
  localparam int AREA_W     = 40;
  localparam int CNT_W      = 13;
  localparam int COUNT_MAX  = 4096;
  localparam int VSUM_W     = VOL_W + 1;
  localparam int ASUM_W     = AREA_W + 1;

  // Stream payloads
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_PAD_W  = OUT_DATA_W - VOL_W - AREA_W - CNT_W;

  // Product schedule
  localparam int OP_NUM     = 12;
  localparam int OP_IDX_W   = 4;
  localparam logic [OP_IDX_W-1:0] OP_LAST = OP_IDX_W'(OP_NUM - 1);

  typedef enum logic [3:0] {
    OPD_UX, OPD_UY, OPD_UZ,
    OPD_WX, OPD_WY, OPD_WZ,
    OPD_AX, OPD_AY, OPD_AZ,
    OPD_NX, OPD_NY, OPD_NZ
  } opd_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_NX, DST_NY, DST_NZ, DST_DOT, DST_LEN2
  } dst_t;

  typedef struct packed {
    logic first;
    logic sub;
    opd_t mcand;
    opd_t mplier;
    dst_t dst;
  } op_t;

  typedef struct packed {
    logic start;
    logic clr;
    logic sub;
  } mac_ctl_t;

  // n = u x w, then a.n, then |n|^2; each group sums into the accumulator
  function automatic op_t op_info(input logic [OP_IDX_W-1:0] idx);
    op_t op;
    op = '{first: 1'b0, sub: 1'b0, mcand: OPD_UX, mplier: OPD_UX, dst: DST_NONE};
    unique case (idx)
      4'd0:    op = '{first: 1'b1, sub: 1'b0, mcand: OPD_UY, mplier: OPD_WZ, dst: DST_NONE};
      4'd1:    op = '{first: 1'b0, sub: 1'b1, mcand: OPD_UZ, mplier: OPD_WY, dst: DST_NX};
      4'd2:    op = '{first: 1'b1, sub: 1'b0, mcand: OPD_UZ, mplier: OPD_WX, dst: DST_NONE};
      4'd3:    op = '{first: 1'b0, sub: 1'b1, mcand: OPD_UX, mplier: OPD_WZ, dst: DST_NY};
      4'd4:    op = '{first: 1'b1, sub: 1'b0, mcand: OPD_UX, mplier: OPD_WY, dst: DST_NONE};
      4'd5:    op = '{first: 1'b0, sub: 1'b1, mcand: OPD_UY, mplier: OPD_WX, dst: DST_NZ};
      4'd6:    op = '{first: 1'b1, sub: 1'b0, mcand: OPD_NX, mplier: OPD_AX, dst: DST_NONE};
      4'd7:    op = '{first: 1'b0, sub: 1'b0, mcand: OPD_NY, mplier: OPD_AY, dst: DST_NONE};
      4'd8:    op = '{first: 1'b0, sub: 1'b0, mcand: OPD_NZ, mplier: OPD_AZ, dst: DST_DOT};
      4'd9:    op = '{first: 1'b1, sub: 1'b0, mcand: OPD_NX, mplier: OPD_NX, dst: DST_NONE};
      4'd10:   op = '{first: 1'b0, sub: 1'b0, mcand: OPD_NY, mplier: OPD_NY, dst: DST_NONE};
      4'd11:   op = '{first: 1'b0, sub: 1'b0, mcand: OPD_NZ, mplier: OPD_NZ, dst: DST_LEN2};
      default: op = '{first: 1'b1, sub: 1'b0, mcand: OPD_UX, mplier: OPD_UX, dst: DST_NONE};
    endcase
    return op;
  endfunction

endpackage

// File: rtl/mvaa_mac.sv
module mvaa_mac
  import mvaa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mac_ctl_t         ctl,
  input  logic [N_W-1:0]   mcand,
  input  logic [N_W-1:0]   mplier,
  output logic             busy,
  output logic [ACC_W-1:0] acc
);

  logic [ACC_W-1:0] mcand_r;
  logic [ACC_W-1:0] acc_r;
  logic [N_W-1:0]   mplier_r;
  logic             busy_r;

  logic [ACC_W-1:0] mcand_ext;
  logic [ACC_W-1:0] mcand_ld;
  logic [N_W-1:0]   mplier_mag;
  logic             neg;
  logic [ACC_W-1:0] pp;

  always_comb begin
    mcand_ext  = {{(ACC_W - N_W){mcand[N_W-1]}}, mcand};
    // fold the multiplier sign and the subtract into the multiplicand
    neg        = ctl.sub ^ mplier[N_W-1];
    mcand_ld   = neg ? (~mcand_ext + ACC_W'(1)) : mcand_ext;
    mplier_mag = mplier[N_W-1] ? (~mplier + N_W'(1)) : mplier;
  end

  always_comb begin
    pp = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (mplier_r[i]) begin
        pp = pp + (mcand_r << i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
    end else if (busy_r) begin
      // stop once no multiplier digits remain
      busy_r <= |mplier_r[N_W-1:DIGIT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand_r  <= mcand_ld;
      mplier_r <= mplier_mag;
      if (ctl.clr) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      acc_r    <= acc_r + pp;
      mcand_r  <= mcand_r << DIGIT_W;
      mplier_r <= mplier_r >> DIGIT_W;
    end
  end

  assign busy = busy_r;
  assign acc  = acc_r;

endmodule

// File: rtl/mvaa_sqrt.sv
module mvaa_sqrt
  import mvaa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ACC_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic [ACC_W-1:0]    x_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SQ_CNT_W-1:0] cnt_r;

  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic                ge;

  always_comb begin
    // bring in the next two radicand bits, try root bit = 1
    rem_sh = {rem_r[ROOT_W-1:0], x_r[ACC_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= SQ_CNT_W'(ROOT_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - SQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      x_r    <= x_r << 2;
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign busy = cnt_r != '0;
  assign root = root_r;

endmodule

// File: rtl/mesh_volume_area_accumulator.sv
// Triangles are taken one at a time: a new one is accepted only after the last one
// has been accumulated. Twelve products share one 4-bit digit-serial multiply-accumulate,
// whose run time is data dependent, then a 26-step bit-pair square root runs;
// a stalled result holds the next last one.
// Reset (synchronous, active low) clears the volume, area and count sums and
// the control state; a pending result is dropped.
module mesh_volume_area_accumulator
  import mvaa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
  // corner_c_x, corner_c_y, corner_c_z (12 bits each), zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // six_volume (52), twice_area (40), triangle_count (13), zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_SQRT  = 5'b01000,
    S_ACCUM = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [OP_IDX_W-1:0]   op_r, op_nxt;
  op_t                   op;

  logic [COORD_BITS-1:0] ax_r, ay_r, az_r;
  logic [DIFF_W-1:0]     ux_r, uy_r, uz_r, wx_r, wy_r, wz_r;
  logic [N_W-1:0]        nx_r, ny_r, nz_r;
  logic [ACC_W-1:0]      dot_r;
  logic                  last_r;

  logic [VOL_W-1:0]      vol_r;
  logic [AREA_W-1:0]     area_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [VOL_W-1:0]      out_vol_r;
  logic [AREA_W-1:0]     out_area_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_valid_r;

  mac_ctl_t              mac_ctl;
  logic                  mac_busy;
  logic [ACC_W-1:0]      mac_acc;
  logic [N_W-1:0]        opd_a, opd_b;
  logic                  sq_start, sq_busy;
  logic [ROOT_W-1:0]     sq_root;

  logic                  in_acc, capture, do_accum;
  logic [COORD_BITS-1:0] cax, cay, caz, cbx, cby, cbz, ccx, ccy, ccz;
  logic [VSUM_W-1:0]     vol_sum;
  logic [VOL_W-1:0]      vol_new;
  logic [ASUM_W-1:0]     area_sum;
  logic [AREA_W-1:0]     area_new;
  logic [CNT_W-1:0]      cnt_new;

  function automatic logic [N_W-1:0] pick(input opd_t sel);
    logic [N_W-1:0] v;
    case (sel)
      OPD_UX:  v = {{(N_W - DIFF_W){ux_r[DIFF_W-1]}}, ux_r};
      OPD_UY:  v = {{(N_W - DIFF_W){uy_r[DIFF_W-1]}}, uy_r};
      OPD_UZ:  v = {{(N_W - DIFF_W){uz_r[DIFF_W-1]}}, uz_r};
      OPD_WX:  v = {{(N_W - DIFF_W){wx_r[DIFF_W-1]}}, wx_r};
      OPD_WY:  v = {{(N_W - DIFF_W){wy_r[DIFF_W-1]}}, wy_r};
      OPD_WZ:  v = {{(N_W - DIFF_W){wz_r[DIFF_W-1]}}, wz_r};
      OPD_AX:  v = {{(N_W - COORD_BITS){ax_r[COORD_BITS-1]}}, ax_r};
      OPD_AY:  v = {{(N_W - COORD_BITS){ay_r[COORD_BITS-1]}}, ay_r};
      OPD_AZ:  v = {{(N_W - COORD_BITS){az_r[COORD_BITS-1]}}, az_r};
      OPD_NX:  v = nx_r;
      OPD_NY:  v = ny_r;
      OPD_NZ:  v = nz_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign in_tready = state_r == S_IDLE;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cax = in_tdata[0 * FIELD_W +: COORD_BITS];
    cay = in_tdata[1 * FIELD_W +: COORD_BITS];
    caz = in_tdata[2 * FIELD_W +: COORD_BITS];
    cbx = in_tdata[3 * FIELD_W +: COORD_BITS];
    cby = in_tdata[4 * FIELD_W +: COORD_BITS];
    cbz = in_tdata[5 * FIELD_W +: COORD_BITS];
    ccx = in_tdata[6 * FIELD_W +: COORD_BITS];
    ccy = in_tdata[7 * FIELD_W +: COORD_BITS];
    ccz = in_tdata[8 * FIELD_W +: COORD_BITS];
  end

  always_comb begin
    op    = op_info(op_r);
    opd_a = pick(op.mcand);
    opd_b = pick(op.mplier);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    mac_ctl   = '0;
    sq_start  = 1'b0;
    capture   = 1'b0;
    do_accum  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_ISSUE;
          op_nxt    = '0;
        end
      end
      S_ISSUE: begin
        mac_ctl.start = 1'b1;
        mac_ctl.clr   = op.first;
        mac_ctl.sub   = op.sub;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (!mac_busy) begin
          capture = 1'b1;
          if (op_r == OP_LAST) begin
            sq_start  = 1'b1;
            state_nxt = S_SQRT;
          end else begin
            op_nxt    = op_r + OP_IDX_W'(1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_SQRT: begin
        if (!sq_busy) begin
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        // hold a closing triangle while the previous result still waits on the output
        if (!(last_r && out_valid_r && !out_tready)) begin
          do_accum  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    vol_sum = {vol_r[VOL_W-1], vol_r} + {{(VSUM_W - ACC_W){dot_r[ACC_W-1]}}, dot_r};
    if (vol_sum[VSUM_W-1] != vol_sum[VSUM_W-2]) begin
      vol_new = vol_sum[VSUM_W-1] ? {1'b1, {(VOL_W - 1){1'b0}}} : {1'b0, {(VOL_W - 1){1'b1}}};
    end else begin
      vol_new = vol_sum[VOL_W-1:0];
    end
    area_sum = {1'b0, area_r} + ASUM_W'(sq_root);
    area_new = area_sum[AREA_W] ? {AREA_W{1'b1}} : area_sum[AREA_W-1:0];
    cnt_new  = (cnt_r < CNT_W'(COUNT_MAX)) ? (cnt_r + CNT_W'(1)) : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= '0;
      out_valid_r <= 1'b0;
      vol_r       <= '0;
      area_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (do_accum && last_r) begin
        out_valid_r <= 1'b1;
        vol_r       <= '0;
        area_r      <= '0;
        cnt_r       <= '0;
      end else begin
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
        if (do_accum) begin
          vol_r  <= vol_new;
          area_r <= area_new;
          cnt_r  <= cnt_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r   <= cax;
      ay_r   <= cay;
      az_r   <= caz;
      ux_r   <= {cbx[COORD_BITS-1], cbx} - {cax[COORD_BITS-1], cax};
      uy_r   <= {cby[COORD_BITS-1], cby} - {cay[COORD_BITS-1], cay};
      uz_r   <= {cbz[COORD_BITS-1], cbz} - {caz[COORD_BITS-1], caz};
      wx_r   <= {ccx[COORD_BITS-1], ccx} - {cax[COORD_BITS-1], cax};
      wy_r   <= {ccy[COORD_BITS-1], ccy} - {cay[COORD_BITS-1], cay};
      wz_r   <= {ccz[COORD_BITS-1], ccz} - {caz[COORD_BITS-1], caz};
      last_r <= in_tlast;
    end
    if (capture) begin
      case (op.dst)
        DST_NX:  nx_r  <= mac_acc[N_W-1:0];
        DST_NY:  ny_r  <= mac_acc[N_W-1:0];
        DST_NZ:  nz_r  <= mac_acc[N_W-1:0];
        DST_DOT: dot_r <= mac_acc;
        default: ;
      endcase
    end
    if (do_accum && last_r) begin
      out_vol_r  <= vol_new;
      out_area_r <= area_new;
      out_cnt_r  <= cnt_new;
    end
  end

  mvaa_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .mcand  (opd_a),
    .mplier (opd_b),
    .busy   (mac_busy),
    .acc    (mac_acc)
  );

  mvaa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (mac_acc),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_area_r, out_vol_r};

endmodule

// File: rtl/mvaa_checker.sv
module mvaa_checker
  import mvaa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [CNT_W-1:0] count;

  assign count = out_tdata[VOL_W + AREA_W +: CNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new triangle taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared right after a triangle was taken");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (count != '0) && (count <= CNT_W'(COUNT_MAX)) &&
                   (out_tdata[OUT_DATA_W-1 -: OUT_PAD_W] == '0))
    else $error("triangle count out of range or pad bits set");

endmodule

bind mesh_volume_area_accumulator mvaa_checker u_mvaa_checker (.*);

// File: tb/mesh_totals_checker.sv
`timescale 1ns / 1ps
module mesh_totals_checker
  import mvaa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatches,
  output int                    awaited
);

  localparam longint SIX_VOL_MAX = (longint'(1) << (VOL_W - 1)) - 1;
  localparam longint SIX_VOL_MIN = -(longint'(1) << (VOL_W - 1));
  localparam longint AREA_CAP    = (longint'(1) << AREA_W) - 1;

  // six_volume sits in the low bits, as on out_tdata
  typedef struct packed {
    logic [CNT_W-1:0]  triangle_count;
    logic [AREA_W-1:0] twice_area;
    logic [VOL_W-1:0]  six_volume;
  } mesh_totals_t;

  mesh_totals_t totals_due[$];
  longint       volume_run = 0;
  longint       area_run = 0;
  int           count_run = 0;
  int           miss_seen = 0;

  assign mismatches = miss_seen;

  function automatic longint grid_coord(input logic [IN_DATA_W-1:0] d, input int idx);
    logic signed [COORD_BITS-1:0] c;
    c = d[idx*FIELD_W +: COORD_BITS];
    return longint'(c);
  endfunction

  function automatic longint floor_root(input longint x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem = x;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return longint'(root);
  endfunction

  task automatic add_triangle(input logic [IN_DATA_W-1:0] d, input logic closes);
    longint ax, ay, az, ux, uy, uz, wx, wy, wz;
    longint nx, ny, nz, dot, len2;
    mesh_totals_t t;
    ax = grid_coord(d, 0);
    ay = grid_coord(d, 1);
    az = grid_coord(d, 2);
    ux = grid_coord(d, 3) - ax;
    uy = grid_coord(d, 4) - ay;
    uz = grid_coord(d, 5) - az;
    wx = grid_coord(d, 6) - ax;
    wy = grid_coord(d, 7) - ay;
    wz = grid_coord(d, 8) - az;
    nx = uy * wz - uz * wy;
    ny = uz * wx - ux * wz;
    nz = ux * wy - uy * wx;
    dot = ax * nx + ay * ny + az * nz;
    len2 = nx * nx + ny * ny + nz * nz;

    volume_run = volume_run + dot;
    if (volume_run > SIX_VOL_MAX) volume_run = SIX_VOL_MAX;
    if (volume_run < SIX_VOL_MIN) volume_run = SIX_VOL_MIN;
    area_run = area_run + floor_root(len2);
    if (area_run > AREA_CAP) area_run = AREA_CAP;
    if (count_run < COUNT_MAX) count_run++;

    if (closes) begin
      t.six_volume     = volume_run[VOL_W-1:0];
      t.twice_area     = area_run[AREA_W-1:0];
      t.triangle_count = count_run[CNT_W-1:0];
      totals_due.insert(totals_due.size(), t);
      volume_run = 0;
      area_run = 0;
      count_run = 0;
    end
  endtask

  task automatic flag_field(input string field, input longint want, input longint got);
    if (miss_seen < 10)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    miss_seen++;
  endtask

  always @(posedge clk) begin
    mesh_totals_t want;
    mesh_totals_t got;
    if (!rst_n) begin
      totals_due.delete();
      volume_run = 0;
      area_run = 0;
      count_run = 0;
    end else begin
      if (in_tvalid && in_tready) add_triangle(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = out_tdata[VOL_W+AREA_W+CNT_W-1:0];
        if (totals_due.size() == 0) begin
          if (miss_seen < 10)
            $display("%0t: result with none pending: volume %0d area %0d count %0d",
                     $time, longint'($signed(got.six_volume)), got.twice_area,
                     got.triangle_count);
          miss_seen++;
        end else begin
          want = totals_due.pop_front();
          if (got.six_volume !== want.six_volume)
            flag_field("six_volume", longint'($signed(want.six_volume)),
                       longint'($signed(got.six_volume)));
          if (got.twice_area !== want.twice_area)
            flag_field("twice_area", want.twice_area, got.twice_area);
          if (got.triangle_count !== want.triangle_count)
            flag_field("triangle_count", want.triangle_count, got.triangle_count);
        end
      end
    end
    awaited <= totals_due.size();
  end

endmodule

// File: tb/tb_mesh_volume_area_accumulator.sv
`timescale 1ns / 1ps
module tb_mesh_volume_area_accumulator
  import mvaa_pkg::*;
();

  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int CALM_ITEMS    = 60;

  typedef logic [2:0][FIELD_W-1:0] point_t;

  typedef enum logic [1:0] {
    SHAPE_WIDE, SHAPE_NEAR, SHAPE_FLAT, SHAPE_SOLID
  } mesh_shape_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int awaited;
  int quiet_cycles = 0;
  int rx_hold = 0;
  bit rx_stalls_on = 1'b0;
  int tx_idle_pct = 0;
  int triangles_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mesh_volume_area_accumulator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mesh_totals_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Result side: stall in random bursts while stalls are enabled
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rx_hold <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("mesh_volume_area_accumulator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic point_t pt(input int x, input int y, input int z);
    return {FIELD_W'(z), FIELD_W'(y), FIELD_W'(x)};
  endfunction

  function automatic point_t rand_point();
    return {FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom)};
  endfunction

  function automatic point_t nudge(input point_t p, input int span);
    point_t q;
    for (int i = 0; i < 3; i++)
      q[i] = p[i] + FIELD_W'(int'($urandom_range(0, 2 * span)) - span);
    return q;
  endfunction

  // p + k*d on each axis; wraps at the grid edge
  function automatic point_t along(input point_t p, input point_t d, input int k);
    point_t q;
    for (int i = 0; i < 3; i++)
      q[i] = p[i] + FIELD_W'(k * $signed(d[i]));
    return q;
  endfunction

  task automatic send_triangle(input point_t a, input point_t b, input point_t c,
                               input logic closes);
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({c, b, a});
    in_tlast <= closes;
    do @(posedge clk); while (!in_tready);
    triangles_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic send_mesh(input int len, input mesh_shape_t shape);
    point_t a, b, c, d;
    point_t corner [4];
    int span;
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_WIDE: begin
          a = rand_point();
          b = rand_point();
          c = rand_point();
        end
        SHAPE_NEAR: begin
          span = $urandom_range(1, 64);
          a = rand_point();
          b = nudge(a, span);
          c = nudge(a, span);
        end
        SHAPE_FLAT: begin
          a = rand_point();
          d = nudge(pt(0, 0, 0), 30);
          b = along(a, d, 1);
          c = along(a, d, $urandom_range(0, 4) - 1);
        end
        default: begin
          // consistently wound faces of a tetrahedron, four per solid
          if (i % 4 == 0) begin
            span = ($urandom_range(0, 3) == 0) ? 2047 : $urandom_range(2, 600);
            corner[0] = rand_point();
            for (int k = 1; k < 4; k++) corner[k] = nudge(corner[0], span);
          end
          case (i % 4)
            0: begin a = corner[0]; b = corner[2]; c = corner[1]; end
            1: begin a = corner[0]; b = corner[1]; c = corner[3]; end
            2: begin a = corner[1]; b = corner[2]; c = corner[3]; end
            default: begin a = corner[0]; b = corner[3]; c = corner[2]; end
          endcase
        end
      endcase
      send_triangle(a, b, c, i == len - 1);
    end
  endtask

  initial begin
    int len;
    mesh_shape_t shape;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // single-triangle meshes: zero, unit and reversed winding
    send_triangle(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), 1'b1);
    send_triangle(pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1), 1'b1);
    send_triangle(pt(0, 0, 1), pt(0, 1, 0), pt(1, 0, 0), 1'b1);
    // corners on the grid extremes
    send_triangle(pt(2047, -2048, -2048), pt(-2048, 2047, -2048),
                  pt(-2048, -2048, 2047), 1'b0);
    send_triangle(pt(-2048, -2048, 2047), pt(-2048, 2047, -2048),
                  pt(2047, -2048, -2048), 1'b0);
    send_triangle(pt(-2048, -2048, -2048), pt(2047, 2047, 2047),
                  pt(-2048, 2047, -2048), 1'b0);
    send_triangle(pt(2047, 2047, 2047), pt(-2048, -2048, -2048),
                  pt(2047, -2048, 2047), 1'b0);
    send_triangle(pt(-2048, -2048, -2048), pt(-2048, -2048, -2048),
                  pt(-2048, -2048, -2048), 1'b1);
    // degenerate: collinear corners, repeated corner
    send_triangle(pt(1, 2, 3), pt(2, 4, 6), pt(3, 6, 9), 1'b0);
    send_triangle(pt(-700, 5, 90), pt(-700, 5, 90), pt(12, -1, 3), 1'b1);
    // closed corner tetrahedron spanning the positive octant
    send_triangle(pt(0, 0, 0), pt(0, 2047, 0), pt(2047, 0, 0), 1'b0);
    send_triangle(pt(0, 0, 0), pt(2047, 0, 0), pt(0, 0, 2047), 1'b0);
    send_triangle(pt(2047, 0, 0), pt(0, 2047, 0), pt(0, 0, 2047), 1'b0);
    send_triangle(pt(0, 0, 0), pt(0, 0, 2047), pt(0, 2047, 0), 1'b1);
    wait_drained();

    while (triangles_sent < RANDOM_ITEMS) begin
      shape = mesh_shape_t'($urandom_range(0, 3));
      if (shape == SHAPE_SOLID)
        len = 4 * $urandom_range(1, 3);
      else if ($urandom_range(0, 3) == 0)
        len = $urandom_range(9, 40);
      else
        len = $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 60;
        default: tx_idle_pct = 20;
      endcase
      rx_stalls_on <= ($urandom_range(0, 3) != 0);
      send_mesh(len, shape);
      if ($urandom_range(0, 14) == 0) wait_drained();
    end

    tx_idle_pct = 0;
    rx_stalls_on <= 1'b0;
    len = triangles_sent + CALM_ITEMS;
    while (triangles_sent < len)
      send_mesh($urandom_range(1, 6), mesh_shape_t'($urandom_range(0, 3)));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("mesh_volume_area_accumulator: match");
    else
      $display("mesh_volume_area_accumulator: mismatch");
    $finish;
  end

endmodule
